// ----- rtl/srdg_pkg.sv -----
// Shared widths, types, item codes and small decimal helpers for the generator.
`default_nettype none
package srdg_pkg;

  localparam int VAL_W = 34;
  localparam int NDIG  = 10;
  localparam int BCD_W = 4 * NDIG;

  typedef logic [VAL_W-1:0] val_t;
  typedef logic [BCD_W-1:0] bcd_t;
  typedef logic [3:0]       digit_t;

  localparam logic KIND_SEED = 1'b0;
  localparam logic KIND_GEN  = 1'b1;

  // Quotient by ten for values below 128, by reciprocal multiplication.
  function automatic digit_t div10_q(logic [6:0] s);
    logic [17:0] p;
    p = 18'(s) * 18'd205;
    return digit_t'(p >> 11);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/srdg_if.sv -----
// Valid/ready channel interfaces for the generator's input and result items.
`default_nettype none
interface srdg_in_if;
  logic                valid;
  logic                ready;
  logic                kind;
  srdg_pkg::val_t      seed_value;

  modport source (output valid, output kind, output seed_value, input ready);
  modport sink   (input valid, input kind, input seed_value, output ready);
endinterface

interface srdg_out_if;
  logic                valid;
  logic                ready;
  srdg_pkg::val_t      random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface
`default_nettype wire

// ----- rtl/super_random_decimal_generator_unit.sv -----
// Top level: decimal digit-serial engine running one Algorithm K per generate item.
//
//   Channel   Direction  Handshake        Payload
//   in_ch     input      valid/ready      kind (1 b), seed_value (34 b)
//   out_ch    output     valid/ready      random_value (34 b)
//
// The value is held as ten BCD digits. A seed item is converted by
// double dabble, which shifts in one binary bit per cycle. A generate
// item runs up to ten passes; each multiply (steps K4, K5, K8, K10, K12) goes
// through one shared digit-by-digit multiply cell, the additions and
// subtractions of K6 and K10 and the shifts of K11 run digit-serially, the
// other steps are single updates, and a final decimal-to-binary conversion
// forms the result. Reset is synchronous and active low and clears the
// value to zero. One item is worked on at a time; a finished result waits
// in the output register, and new items are taken while it waits.
`default_nettype none
module super_random_decimal_generator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  srdg_in_if.sink          in_ch,
  srdg_out_if.source       out_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_SEED, S_PASS, S_STEP, S_MUL, S_ADD, S_NORM, S_CONV
  } state_t;

  typedef enum logic [1:0] {
    OP_ADD_K6, OP_NEG, OP_ADD_K10, OP_SUB_K10
  } op_t;

  localparam logic [3:0] K3  = 4'd3;
  localparam logic [3:0] K4  = 4'd4;
  localparam logic [3:0] K5  = 4'd5;
  localparam logic [3:0] K6  = 4'd6;
  localparam logic [3:0] K7  = 4'd7;
  localparam logic [3:0] K8  = 4'd8;
  localparam logic [3:0] K9  = 4'd9;
  localparam logic [3:0] K10 = 4'd10;
  localparam logic [3:0] K11 = 4'd11;
  localparam logic [3:0] K12 = 4'd12;

  // Decimal constants of the algorithm, one BCD digit per nibble.
  localparam srdg_pkg::bcd_t BCD_MULT   = 40'h1001001001;
  localparam srdg_pkg::bcd_t BCD_K6ADD  = 40'h9814055677;
  localparam srdg_pkg::bcd_t BCD_K10ADD = 40'h0000099999;

  localparam int DD_W = srdg_pkg::BCD_W + 4;

  function automatic srdg_pkg::digit_t digit_of(srdg_pkg::bcd_t v, logic [3:0] i);
    srdg_pkg::digit_t d;
    d = '0;
    for (int k = 0; k < srdg_pkg::NDIG; k++) begin
      if (i == 4'(k)) d = v[4*k +: 4];
    end
    return d;
  endfunction

  // Subtract one from a nonzero decimal value.
  function automatic srdg_pkg::bcd_t bcd_dec(srdg_pkg::bcd_t v);
    srdg_pkg::bcd_t r;
    logic           bw;
    r  = v;
    bw = 1'b1;
    for (int k = 0; k < srdg_pkg::NDIG; k++) begin
      if (bw) begin
        if (v[4*k +: 4] == 4'd0) begin
          r[4*k +: 4] = 4'd9;
        end else begin
          r[4*k +: 4] = v[4*k +: 4] - 4'd1;
          bw          = 1'b0;
        end
      end
    end
    return r;
  endfunction

  // Step K9: every nonzero digit goes down by one.
  function automatic srdg_pkg::bcd_t digits_dec(srdg_pkg::bcd_t v);
    srdg_pkg::bcd_t r;
    for (int k = 0; k < srdg_pkg::NDIG; k++) begin
      r[4*k +: 4] = (v[4*k +: 4] == 4'd0) ? 4'd0 : v[4*k +: 4] - 4'd1;
    end
    return r;
  endfunction

  function automatic logic all_bcd(srdg_pkg::bcd_t v);
    logic ok;
    ok = 1'b1;
    for (int k = 0; k < srdg_pkg::NDIG; k++) begin
      if (v[4*k +: 4] > 4'd9) ok = 1'b0;
    end
    return ok;
  endfunction

  state_t               state_r, state_nxt;
  srdg_pkg::bcd_t       x_r, x_nxt;
  srdg_pkg::digit_t     y_r, y_nxt;
  logic [3:0]           step_r, step_nxt;
  logic [5:0]           cnt_r, cnt_nxt;
  logic [DD_W-1:0]      dd_r, dd_nxt;
  srdg_pkg::val_t       bin_r, bin_nxt;
  srdg_pkg::bcd_t       ma_r, ma_nxt, mb_r, mb_nxt, mw_r, mw_nxt, ml_r, ml_nxt;
  srdg_pkg::digit_t     mc_r, mc_nxt;
  logic [3:0]           icnt_r, icnt_nxt, jcnt_r, jcnt_nxt;
  op_t                  op_r, op_nxt;
  logic                 cy_r, cy_nxt;
  srdg_pkg::val_t       acc_r, acc_nxt;
  logic                 out_val_r, out_val_nxt;
  srdg_pkg::val_t       out_data_r, out_data_nxt;

  // Multiply cell: one digit product per cycle into a rotating ten-digit window.
  logic [6:0]           m_sum;
  srdg_pkg::digit_t     m_q, m_r;
  srdg_pkg::bcd_t       mw_fin, ml_fin, mul_mid;

  assign m_sum   = 7'(ma_r[3:0]) * 7'(mb_r[3:0]) + 7'(mw_r[3:0]) + 7'(mc_r);
  assign m_q     = srdg_pkg::div10_q(m_sum);
  assign m_r     = 4'(m_sum - 7'(m_q) * 7'd10);
  assign mw_fin  = {mc_r, mw_r[srdg_pkg::BCD_W-1:4]};
  assign ml_fin  = {mw_r[3:0], ml_r[srdg_pkg::BCD_W-1:4]};
  // Digits five to fourteen of the twenty-digit product.
  assign mul_mid = {mw_fin[19:0], ml_fin[srdg_pkg::BCD_W-1:20]};

  // Serial decimal adder and subtractor working on the low digit of x.
  srdg_pkg::digit_t     a_dig, k_dig, add_res;
  logic [4:0]           add_t;
  logic                 add_cy;

  always_comb begin
    a_dig = x_r[3:0];
    case (op_r)
      OP_ADD_K6:  k_dig = digit_of(BCD_K6ADD, cnt_r[3:0]);
      OP_ADD_K10: k_dig = digit_of(BCD_K10ADD, cnt_r[3:0]);
      OP_SUB_K10: k_dig = digit_of(BCD_K10ADD, cnt_r[3:0]);
      default:    k_dig = '0;
    endcase
    case (op_r)
      OP_ADD_K6, OP_ADD_K10: begin
        add_t = {1'b0, a_dig} + {1'b0, k_dig} + {4'b0, cy_r};
        if (add_t >= 5'd10) begin
          add_res = 4'(add_t - 5'd10);
          add_cy  = 1'b1;
        end else begin
          add_res = add_t[3:0];
          add_cy  = 1'b0;
        end
      end
      default: begin
        if (op_r == OP_NEG) begin
          add_t = 5'd0 - {1'b0, a_dig} - {4'b0, cy_r};
        end else begin
          add_t = {1'b0, a_dig} - {1'b0, k_dig} - {4'b0, cy_r};
        end
        if (add_t[4]) begin
          add_res = 4'(add_t + 5'd10);
          add_cy  = 1'b1;
        end else begin
          add_res = add_t[3:0];
          add_cy  = 1'b0;
        end
      end
    endcase
  end

  // Double-dabble correction of every digit before the next shift.
  logic [DD_W-1:0]      dd_adj;
  always_comb begin
    for (int k = 0; k < DD_W / 4; k++) begin
      dd_adj[4*k +: 4] = (dd_r[4*k +: 4] >= 4'd5) ? dd_r[4*k +: 4] + 4'd3
                                                   : dd_r[4*k +: 4];
    end
  end

  // Where the step chain goes after the current step completes.
  state_t               adv_state;
  logic [3:0]           adv_step;
  srdg_pkg::digit_t     adv_y;
  always_comb begin
    adv_state = S_STEP;
    adv_step  = step_r + 4'd1;
    adv_y     = y_r;
    if (step_r == K12) begin
      adv_step = step_r;
      if (y_r == 4'd0) begin
        adv_state = S_CONV;
      end else begin
        adv_state = S_PASS;
        adv_y     = y_r - 4'd1;
      end
    end
  end

  logic in_take;
  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_take             = in_ch.valid && (state_r == S_IDLE);
  assign out_ch.valid        = out_val_r;
  assign out_ch.random_value = out_data_r;

  always_comb begin
    state_nxt    = state_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    step_nxt     = step_r;
    cnt_nxt      = cnt_r;
    dd_nxt       = dd_r;
    bin_nxt      = bin_r;
    ma_nxt       = ma_r;
    mb_nxt       = mb_r;
    mw_nxt       = mw_r;
    ml_nxt       = ml_r;
    mc_nxt       = mc_r;
    icnt_nxt     = icnt_r;
    jcnt_nxt     = jcnt_r;
    op_nxt       = op_r;
    cy_nxt       = cy_r;
    acc_nxt      = acc_r;
    out_val_nxt  = out_val_r && !out_ch.ready;
    out_data_nxt = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_ch.kind == srdg_pkg::KIND_SEED) begin
            bin_nxt   = in_ch.seed_value;
            dd_nxt    = '0;
            cnt_nxt   = '0;
            state_nxt = S_SEED;
          end else begin
            y_nxt     = x_r[srdg_pkg::BCD_W-1 -: 4];
            state_nxt = S_PASS;
          end
        end
      end
      S_SEED: begin
        if (cnt_r < 6'(srdg_pkg::VAL_W)) begin
          dd_nxt  = {dd_adj[DD_W-2:0], bin_r[srdg_pkg::VAL_W-1]};
          bin_nxt = {bin_r[srdg_pkg::VAL_W-2:0], 1'b0};
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          // The eleventh digit is dropped, which reduces the seed mod 10^10.
          x_nxt     = dd_r[srdg_pkg::BCD_W-1:0];
          state_nxt = S_IDLE;
        end
      end
      S_PASS: begin
        step_nxt  = x_r[35:32] + K3;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        state_nxt = adv_state;
        step_nxt  = adv_step;
        y_nxt     = adv_y;
        cnt_nxt   = '0;
        acc_nxt   = '0;
        mw_nxt    = '0;
        ml_nxt    = '0;
        mc_nxt    = '0;
        icnt_nxt  = '0;
        jcnt_nxt  = '0;
        cy_nxt    = 1'b0;
        ma_nxt    = x_r;
        mb_nxt    = x_r;
        case (step_r)
          K3: begin
            if (x_r[39:36] < 4'd5) x_nxt[39:36] = x_r[39:36] + 4'd5;
          end
          K4: begin
            state_nxt = S_MUL;
            step_nxt  = step_r;
            y_nxt     = y_r;
          end
          K5, K8: begin
            mb_nxt    = BCD_MULT;
            state_nxt = S_MUL;
            step_nxt  = step_r;
            y_nxt     = y_r;
          end
          K6: begin
            op_nxt    = (x_r[39:32] == 8'd0) ? OP_ADD_K6 : OP_NEG;
            state_nxt = S_ADD;
            step_nxt  = step_r;
            y_nxt     = y_r;
          end
          K7: begin
            x_nxt = {x_r[19:0], x_r[39:20]};
          end
          K9: begin
            x_nxt = digits_dec(x_r);
          end
          K10: begin
            if (x_r[39:20] == 20'd0) begin
              state_nxt = S_MUL;
            end else begin
              op_nxt    = OP_SUB_K10;
              state_nxt = S_ADD;
            end
            step_nxt = step_r;
            y_nxt    = y_r;
          end
          K11: begin
            state_nxt = S_NORM;
            step_nxt  = step_r;
            y_nxt     = y_r;
          end
          K12: begin
            // A zero value stays zero; otherwise form X times X minus one.
            if (x_r != '0) begin
              ma_nxt    = bcd_dec(x_r);
              state_nxt = S_MUL;
              step_nxt  = step_r;
              y_nxt     = y_r;
            end
          end
          default: ;
        endcase
      end
      S_MUL: begin
        if (icnt_r != 4'd10) begin
          ma_nxt   = {ma_r[3:0], ma_r[srdg_pkg::BCD_W-1:4]};
          mw_nxt   = {m_r, mw_r[srdg_pkg::BCD_W-1:4]};
          mc_nxt   = m_q;
          icnt_nxt = icnt_r + 4'd1;
        end else begin
          ml_nxt   = ml_fin;
          mw_nxt   = mw_fin;
          mc_nxt   = '0;
          mb_nxt   = {mb_r[3:0], mb_r[srdg_pkg::BCD_W-1:4]};
          icnt_nxt = '0;
          jcnt_nxt = jcnt_r + 4'd1;
          if (jcnt_r == 4'd9) begin
            cnt_nxt = '0;
            acc_nxt = '0;
            cy_nxt  = 1'b0;
            if (step_r == K4 || step_r == K12) begin
              x_nxt     = mul_mid;
              state_nxt = adv_state;
              step_nxt  = adv_step;
              y_nxt     = adv_y;
            end else if (step_r == K10) begin
              x_nxt     = ml_fin;
              op_nxt    = OP_ADD_K10;
              state_nxt = S_ADD;
            end else begin
              x_nxt     = ml_fin;
              state_nxt = adv_state;
              step_nxt  = adv_step;
              y_nxt     = adv_y;
            end
          end
        end
      end
      S_ADD: begin
        x_nxt   = {add_res, x_r[srdg_pkg::BCD_W-1:4]};
        cy_nxt  = add_cy;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd9) begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = adv_state;
          step_nxt  = adv_step;
          y_nxt     = adv_y;
        end
      end
      S_NORM: begin
        if (x_r[39:36] == 4'd0 && cnt_r < 6'd10) begin
          x_nxt   = {x_r[srdg_pkg::BCD_W-5:0], 4'd0};
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          cnt_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = adv_state;
          step_nxt  = adv_step;
          y_nxt     = adv_y;
        end
      end
      S_CONV: begin
        if (cnt_r < 6'd10) begin
          acc_nxt = (acc_r << 3) + (acc_r << 1)
                  + {{(srdg_pkg::VAL_W-4){1'b0}}, x_r[39:36]};
          x_nxt   = {x_r[srdg_pkg::BCD_W-5:0], x_r[39:36]};
          cnt_nxt = cnt_r + 6'd1;
        end else if (!out_val_r || out_ch.ready) begin
          out_data_nxt = acc_r;
          out_val_nxt  = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      x_r       <= '0;
      out_val_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      x_r       <= x_nxt;
      out_val_r <= out_val_nxt;
    end
    y_r        <= y_nxt;
    step_r     <= step_nxt;
    cnt_r      <= cnt_nxt;
    dd_r       <= dd_nxt;
    bin_r      <= bin_nxt;
    ma_r       <= ma_nxt;
    mb_r       <= mb_nxt;
    mw_r       <= mw_nxt;
    ml_r       <= ml_nxt;
    mc_r       <= mc_nxt;
    icnt_r     <= icnt_nxt;
    jcnt_r     <= jcnt_nxt;
    op_r       <= op_nxt;
    cy_r       <= cy_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  // A generate item always opens a pass on the next cycle.
  a_gen_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_ch.kind == srdg_pkg::KIND_GEN) |=> state_r == S_PASS)
    else $error("generate item did not start a pass");

  // The value holds only decimal digits whenever a pass begins.
  a_bcd_value: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PASS |-> all_bcd(x_r))
    else $error("value holds a non-decimal digit");

  // The step chain never leaves K3 to K12.
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STEP |-> (step_r >= K3 && step_r <= K12))
    else $error("step out of range");

  // The multiply cell counters stay within one ten-by-ten digit sweep.
  a_mul_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MUL |-> (icnt_r <= 4'd10 && jcnt_r <= 4'd9))
    else $error("multiply counter overrun");

endmodule
`default_nettype wire

// ----- test/tb_super_random_decimal_generator_unit.sv -----
// Testbench for the super-random decimal generator: seeds, generate items, self-checking.
`default_nettype none
module tb_super_random_decimal_generator_unit;

  localparam longint unsigned TEN10 = 64'd10000000000;
  localparam longint unsigned TEN9  = 64'd1000000000;
  localparam longint unsigned TEN8  = 64'd100000000;
  localparam longint unsigned TEN5  = 64'd100000;
  localparam longint unsigned HALF  = 64'd5000000000;
  localparam longint unsigned KMUL  = 64'd1001001001;
  localparam longint unsigned K6ADD = 64'd9814055677;
  localparam longint unsigned K10ADD = 64'd99999;
  // The limit allows for the worst-case generate item time plus stalls.
  localparam longint CYCLE_LIMIT = 64'd30000000;

  typedef struct packed {
    logic kind;
    srdg_pkg::val_t seed_value;
  } gen_item_t;

  logic clk;
  logic rst_n;

  srdg_in_if  in_ch ();
  srdg_out_if out_ch ();

  super_random_decimal_generator_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  gen_item_t       pending_items[$];
  srdg_pkg::val_t  expected_values[$];
  longint unsigned model_value;
  int              mismatch_count;
  int              checked_count;
  int              seed_count;
  int              gen_count;
  longint          cycle_count;
  bit              stimulus_done;
  int              send_wait;
  int              recv_wait;
  int              hold_cycles;

  // floor(p*q / 10^5) mod 10^10, with the product split to stay in 64 bits.
  function automatic longint unsigned mul_mid(longint unsigned p, longint unsigned q);
    longint unsigned a1, b1, a2, b2, s;
    a1 = p / TEN5;
    b1 = p % TEN5;
    a2 = q / TEN5;
    b2 = q % TEN5;
    s = ((a1 * a2) % TEN5) * TEN5;
    s += a1 * b2 + a2 * b1 + (b1 * b2) / TEN5;
    return s % TEN10;
  endfunction

  function automatic longint unsigned digits_down(longint unsigned x);
    longint unsigned r, scale, d;
    r = 0;
    scale = 1;
    for (int i = 0; i < 10; i++) begin
      d = x % 10;
      if (d != 0) d -= 1;
      r += d * scale;
      scale *= 10;
      x /= 10;
    end
    return r;
  endfunction

  // One full run of the super-random algorithm on a ten-digit value.
  function automatic longint unsigned knuth_next(longint unsigned x);
    longint unsigned y;
    int entry;
    y = x / TEN9;
    forever begin
      entry = int'((x / TEN8) % 10) + 3;
      for (int st = entry; st <= 12; st++) begin
        case (st)
          3: begin
            if (x < HALF) x += HALF;
          end
          4: x = mul_mid(x, x);
          5, 8: x = (KMUL * x) % TEN10;
          6: begin
            if (x < TEN8) x += K6ADD;
            else x = TEN10 - x;
          end
          7: x = (x % TEN5) * TEN5 + x / TEN5;
          9: x = digits_down(x);
          10: begin
            if (x < TEN5) x = x * x + K10ADD;
            else x -= K10ADD;
          end
          11: begin
            for (int n = 0; n < 10 && x < TEN9; n++) x *= 10;
          end
          default: x = (x == 0) ? 0 : mul_mid(x, x - 1);
        endcase
      end
      if (y == 0) break;
      y -= 1;
    end
    return x;
  endfunction

  task automatic report_mismatch(input string what, input srdg_pkg::val_t got,
                                 input srdg_pkg::val_t want);
    mismatch_count++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  function automatic void queue_item(logic kind, srdg_pkg::val_t value);
    gen_item_t it;
    it.kind = kind;
    it.seed_value = value;
    pending_items.push_back(it);
  endfunction

  function automatic srdg_pkg::val_t random_seed();
    srdg_pkg::val_t v;
    v = srdg_pkg::val_t'({$urandom, $urandom});
    case ($urandom_range(0, 5))
      0: v = srdg_pkg::val_t'($urandom_range(0, 999));
      1: v = srdg_pkg::val_t'(64'(v) % TEN10);
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Directed part, then random bursts: a seed followed by a run of generates,
  // mixed with back-to-back seeds and lone generates.
  initial begin
    int burst;
    queue_item(srdg_pkg::KIND_GEN, '0);
    queue_item(srdg_pkg::KIND_GEN, '1);
    queue_item(srdg_pkg::KIND_SEED, '1);
    queue_item(srdg_pkg::KIND_GEN, '0);
    queue_item(srdg_pkg::KIND_SEED, srdg_pkg::val_t'(64'd9999999999));
    queue_item(srdg_pkg::KIND_GEN, '0);
    queue_item(srdg_pkg::KIND_SEED, srdg_pkg::val_t'(64'd10000000000));
    queue_item(srdg_pkg::KIND_GEN, '0);
    queue_item(srdg_pkg::KIND_SEED, '0);
    queue_item(srdg_pkg::KIND_GEN, '0);
    for (int z = 0; z < 10; z++) begin
      queue_item(srdg_pkg::KIND_SEED, srdg_pkg::val_t'(64'(z) * TEN8 + 64'd1234567));
      queue_item(srdg_pkg::KIND_GEN, srdg_pkg::val_t'({$urandom, $urandom}));
    end
    queue_item(srdg_pkg::KIND_SEED, srdg_pkg::val_t'(64'd99999));
    queue_item(srdg_pkg::KIND_GEN, '0);
    queue_item(srdg_pkg::KIND_SEED, srdg_pkg::val_t'(64'd5000000000));
    queue_item(srdg_pkg::KIND_GEN, '0);
    while (pending_items.size() < 750) begin
      if ($urandom_range(0, 9) < 7) begin
        queue_item(srdg_pkg::KIND_SEED, random_seed());
        burst = $urandom_range(1, 6);
        for (int i = 0; i < burst; i++)
          queue_item(srdg_pkg::KIND_GEN, srdg_pkg::val_t'({$urandom, $urandom}));
      end else begin
        queue_item(logic'($urandom_range(0, 1)), random_seed());
      end
    end
  end

  // Driver: offers the oldest pending item after a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.kind <= srdg_pkg::KIND_SEED;
      in_ch.seed_value <= '0;
      send_wait <= 0;
      model_value <= 0;
    end else if (in_ch.valid && in_ch.ready) begin
      if (in_ch.kind == srdg_pkg::KIND_SEED) begin
        model_value <= 64'(in_ch.seed_value) % TEN10;
        seed_count++;
      end else begin
        expected_values.push_back(srdg_pkg::val_t'(knuth_next(model_value)));
        model_value <= knuth_next(model_value);
        gen_count++;
      end
      in_ch.valid <= 1'b0;
      send_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
    end else if (!in_ch.valid) begin
      if (send_wait > 0) begin
        send_wait <= send_wait - 1;
      end else if (pending_items.size() > 0) begin
        gen_item_t it;
        it = pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.kind <= it.kind;
        in_ch.seed_value <= it.seed_value;
      end else begin
        stimulus_done <= 1'b1;
      end
    end
  end

  // Receiver: random stalls per item, plus one long hold-off early in the run
  // so the result register fills and the block stops taking items.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      recv_wait <= 0;
      hold_cycles <= 20000;
    end else if (checked_count == 30 && hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (out_ch.valid && out_ch.ready) begin
      checked_count++;
      if (expected_values.size() == 0) begin
        report_mismatch("unexpected random_value", out_ch.random_value, '0);
      end else begin
        srdg_pkg::val_t want;
        want = expected_values.pop_front();
        if (out_ch.random_value !== want)
          report_mismatch("random_value", out_ch.random_value, want);
      end
      recv_wait <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
      out_ch.ready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait <= recv_wait - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", expected_values.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    checked_count = 0;
    seed_count = 0;
    gen_count = 0;
    cycle_count = 0;
    stimulus_done = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = srdg_pkg::KIND_SEED;
    in_ch.seed_value = '0;
    out_ch.ready = 1'b0;
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (stimulus_done && expected_values.size() == 0);
    // Allow a stray extra result to show up before closing.
    repeat (7000) @(posedge clk);
    $display("run covered %0d seed items and %0d generate items", seed_count, gen_count);
    $display("%0d results checked, %0d mismatches", checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
